### hdl/two_level_code_pointer_map_top_assert.svh
// assertion macros for the two-level code pointer map
// expects signals named clock and reset in the scope of each use
`ifndef TWO_LEVEL_CODE_POINTER_MAP_TOP_ASSERT_SVH
`define TWO_LEVEL_CODE_POINTER_MAP_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define TCPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequence required in the cycle after the trigger
`define TCPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tcpm_pkg.sv
// shared types and constants for the two-level code pointer map
// no dependencies
`default_nettype none

package tcpm_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_LOOKUP      = 2'd0,
      ACT_STORE       = 2'd1,
      ACT_SET_DEFAULT = 2'd2,
      ACT_FLUSH       = 2'd3
   } action_type;

   // response status codes
   localparam logic ST_DONE     = 1'b0;
   localparam logic ST_NO_TABLE = 1'b1;

   // request and response field layout
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int MODE_LSB    = 0;
   localparam int MODE_FW     = 2;
   localparam int PC_LSB      = 2;
   localparam int PC_FW       = 32;
   localparam int CODE_LSB    = 34;
   localparam int CODE_FW     = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 1;

   // first-level map port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } l1_ctl_type;

   // table pool port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic fill_start;
      logic rewrite_start;
   } pool_ctl_type;

endpackage

`default_nettype wire

### hdl/tcpm_l1_map.sv
// first-level map memory: valid bit plus table number per slot, with clearing sweep
// depends on tcpm_pkg
`default_nettype none

module tcpm_l1_map #(
   parameter int ADDR_W = 10,
   parameter int TBL_W  = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcpm_pkg::l1_ctl_type ctl,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [TBL_W-1:0]     wr_table,
   output logic                      rd_valid,
   output logic [TBL_W-1:0]          rd_table,
   output logic                      busy
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [TBL_W:0]      mem [DEPTH];
   logic [TBL_W:0]      rd_q_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                clr_busy_ff, clr_busy_in;

   // clearing sweep, one slot per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (ctl.clear) begin
         clr_busy_in = 1'b1;
         clr_cnt_in  = '0;
      end else if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // memory array, sweep has the write port while clearing
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem[wr_addr] <= {1'b1, wr_table};
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_valid = rd_q_ff[TBL_W];
   assign rd_table = rd_q_ff[TBL_W-1:0];
   assign busy     = clr_busy_ff;

endmodule

`default_nettype wire

### hdl/tcpm_pool.sv
// second-level table pool memory with fill and default-rewrite sweeps
// depends on tcpm_pkg
`default_nettype none

module tcpm_pool #(
   parameter int TBL_W   = 6,
   parameter int L2_BITS = 8,
   parameter int CODE_W  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tcpm_pkg::pool_ctl_type ctl,
   input  wire logic [TBL_W+((L2_BITS > 0) ? L2_BITS : 1)-1:0] addr,
   input  wire logic [CODE_W-1:0]      wr_data,
   input  wire logic [TBL_W-1:0]       fill_table,
   input  wire logic [TBL_W:0]         sweep_limit,
   input  wire logic [CODE_W-1:0]      sweep_value,
   input  wire logic [CODE_W-1:0]      old_value,
   output logic [CODE_W-1:0]           rd_data,
   output logic                        busy
);

   localparam int L2_W    = (L2_BITS > 0) ? L2_BITS : 1;
   localparam int L2_SIZE = 1 << L2_BITS;
   localparam int AW      = TBL_W + L2_W;
   localparam int DEPTH   = 1 << AW;

   typedef enum logic [1:0] {
      P_IDLE,
      P_FILL,
      P_REWRITE
   } sweep_type;

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_q_ff;

   sweep_type         sw_ff, sw_in;
   logic [TBL_W:0]    tbl_ff, tbl_in;
   logic [L2_W-1:0]   idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;

   logic [AW-1:0]     sweep_addr;
   logic              idx_last;
   logic              rw_issue;
   logic              we, re;
   logic [AW-1:0]     waddr, raddr;
   logic [CODE_W-1:0] wdata;

   assign sweep_addr = {tbl_ff[TBL_W-1:0], idx_ff};
   assign idx_last   = (idx_ff == L2_W'(L2_SIZE - 1));
   assign rw_issue   = (sw_ff == P_REWRITE) && (tbl_ff != sweep_limit);

   // sweep sequencer
   always_comb begin
      sw_in        = sw_ff;
      tbl_in       = tbl_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      unique case (sw_ff)
         P_IDLE: begin
            if (ctl.fill_start) begin
               sw_in  = P_FILL;
               tbl_in = {1'b0, fill_table};
               idx_in = '0;
            end else if (ctl.rewrite_start) begin
               sw_in  = P_REWRITE;
               tbl_in = '0;
               idx_in = '0;
            end
         end
         P_FILL: begin
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               sw_in = P_IDLE;
            end
         end
         P_REWRITE: begin
            if (rw_issue) begin
               pend_in      = 1'b1;
               pend_addr_in = sweep_addr;
               if (idx_last) begin
                  idx_in = '0;
                  tbl_in = tbl_ff + 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               sw_in = P_IDLE;
            end
         end
         default: sw_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff   <= P_IDLE;
         pend_ff <= 1'b0;
      end else begin
         sw_ff   <= sw_in;
         pend_ff <= pend_in;
      end
      tbl_ff       <= tbl_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
   end

   // port arbitration: sweeps own the memory while running
   always_comb begin
      we    = 1'b0;
      waddr = addr;
      wdata = wr_data;
      if (sw_ff == P_FILL) begin
         we    = 1'b1;
         waddr = sweep_addr;
         wdata = sweep_value;
      end else if (pend_ff && (rd_q_ff == old_value)) begin
         we    = 1'b1;
         waddr = pend_addr_ff;
         wdata = sweep_value;
      end else if (ctl.wr_en) begin
         we = 1'b1;
      end
      re    = ctl.rd_en;
      raddr = addr;
      if (rw_issue) begin
         re    = 1'b1;
         raddr = sweep_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_q_ff <= mem[raddr];
      end
   end

   assign rd_data = rd_q_ff;
   assign busy    = (sw_ff != P_IDLE) || pend_ff;

endmodule

`default_nettype wire

### hdl/two_level_code_pointer_map_top.sv
// top level of the two-level code pointer map: request sequencer and response register
// depends on tcpm_pkg, tcpm_l1_map, tcpm_pool and the assertion macro header
//
// Usage:
//   req channel carries one request: lookup, store, set default pointer or flush
//   (req_tuser). rsp channel returns exactly one response per request, in order.
//   A lookup of a mapped slot goes through a first-level map read, then a table
//   read (both synchronous memories with registered read data). A lookup of an
//   unmapped slot, a store into a mapped slot and a store that finds the pool empty
//   finish after the map read; a lookup or store with a mode out of range reads no memory.
//   A store that takes a new table first fills it with the default pointer through
//   the pool write port, then writes the stored code.
//   Set default answers without waiting for the sweep it starts: when the pointer
//   changes, the pool rewrite sweep walks all taken tables. A flush also answers before
//   its sweep, then the first-level map clearing sweep clears all 2^(mode bits + L1 bits)
//   slots (1024 with default parameters). req_tready stays low during either sweep.
//   After reset the same clearing sweep runs before the first request is taken.
//   A response waits in the output register while rsp_tready is low; one more
//   finished response can be parked behind it, after which requests stall.
`default_nettype none

`include "two_level_code_pointer_map_top_assert.svh"

module two_level_code_pointer_map_top #(
   parameter int MODES       = 4,
   parameter int ADDR_BITS   = 18,
   parameter int IGNORE_BITS = 2,
   parameter int POOL_TABLES = 64,
   parameter int CODE_BITS   = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // mode [1:0], pc [33:2], code_value [65:34], zero [71:66]
   input  wire logic [tcpm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action [1:0]
   input  wire logic [tcpm_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // code_out [31:0]
   output logic [tcpm_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // status [0]
   output logic [tcpm_pkg::RSP_TUSER_W-1:0]         rsp_tuser
);

   localparam int EFF_BITS = (ADDR_BITS > IGNORE_BITS) ? ADDR_BITS - IGNORE_BITS : 0;
   localparam int L1_BITS  = EFF_BITS / 2;
   localparam int L2_BITS  = EFF_BITS - L1_BITS;
   localparam int L1_W     = (L1_BITS > 0) ? L1_BITS : 1;
   localparam int L2_W     = (L2_BITS > 0) ? L2_BITS : 1;
   localparam int L1_SHIFT = IGNORE_BITS + L2_BITS;
   localparam int L2_SHIFT = IGNORE_BITS;
   localparam int L1_MASK  = (1 << L1_BITS) - 1;
   localparam int L2_MASK  = (1 << L2_BITS) - 1;
   localparam int MODE_W   = (MODES > 1) ? $clog2(MODES) : 1;
   localparam int TBL_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int L1A_W    = MODE_W + L1_W;
   localparam int PA_W     = TBL_W + L2_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_L1,
      S_POOL,
      S_FILL,
      S_HOLD
   } state_type;

   // request fields
   tcpm_pkg::action_type  req_act;
   logic [tcpm_pkg::MODE_FW-1:0] req_mode;
   logic [tcpm_pkg::PC_FW-1:0]   req_pc;
   logic [tcpm_pkg::CODE_FW-1:0] req_code_val;
   logic [CODE_BITS-1:0]  req_code;
   logic                  req_mode_ok;
   logic [L1_W-1:0]       req_l1;
   logic [L2_W-1:0]       req_l2;
   logic [L1A_W-1:0]      req_l1a;

   // sequencer state
   state_type             state_ff, state_in;
   tcpm_pkg::action_type  act_ff, act_in;
   logic [L1A_W-1:0]      l1a_ff, l1a_in;
   logic [L2_W-1:0]       l2_ff, l2_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [CODE_BITS-1:0]  default_ff, default_in;
   logic [CODE_BITS-1:0]  old_ff, old_in;
   logic [TBL_W:0]        nf_ff, nf_in;
   logic [TBL_W-1:0]      cur_tbl_ff, cur_tbl_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcpm_pkg::RSP_TDATA_W-1:0] rsp_code_ff, rsp_code_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [tcpm_pkg::RSP_TDATA_W-1:0] hold_code_ff, hold_code_in;
   logic                  hold_status_ff, hold_status_in;

   // finishing request
   logic                  fin_en;
   logic [tcpm_pkg::RSP_TDATA_W-1:0] fin_code;
   logic                  fin_status;
   logic                  out_free;
   logic                  ready;

   // memory ports
   tcpm_pkg::l1_ctl_type   l1_ctl;
   tcpm_pkg::pool_ctl_type pool_ctl;
   logic                   l1_rd_valid;
   logic [TBL_W-1:0]       l1_rd_table;
   logic                   l1_busy;
   logic [PA_W-1:0]        pool_addr;
   logic [CODE_BITS-1:0]   pool_rd_data;
   logic                   pool_busy;

   // field extraction and index split
   assign req_act      = tcpm_pkg::action_type'(req_tuser);
   assign req_mode     = req_tdata[tcpm_pkg::MODE_LSB +: tcpm_pkg::MODE_FW];
   assign req_pc       = req_tdata[tcpm_pkg::PC_LSB +: tcpm_pkg::PC_FW];
   assign req_code_val = req_tdata[tcpm_pkg::CODE_LSB +: tcpm_pkg::CODE_FW];
   assign req_code     = CODE_BITS'(req_code_val);
   assign req_mode_ok  = (32'(req_mode) < 32'(MODES));
   assign req_l1       = L1_W'((req_pc >> L1_SHIFT) & 32'(L1_MASK));
   assign req_l2       = L2_W'((req_pc >> L2_SHIFT) & 32'(L2_MASK));
   assign req_l1a      = {MODE_W'(req_mode), req_l1};

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign ready    = (state_ff == S_IDLE) && !l1_busy && !pool_busy;

   // request sequencer
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      l1a_in         = l1a_ff;
      l2_in          = l2_ff;
      code_in        = code_ff;
      default_in     = default_ff;
      old_in         = old_ff;
      nf_in          = nf_ff;
      cur_tbl_in     = cur_tbl_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_code_in    = rsp_code_ff;
      rsp_status_in  = rsp_status_ff;
      hold_code_in   = hold_code_ff;
      hold_status_in = hold_status_ff;
      l1_ctl         = '0;
      pool_ctl       = '0;
      pool_addr      = {cur_tbl_ff, l2_ff};
      fin_en         = 1'b0;
      fin_code       = '0;
      fin_status     = tcpm_pkg::ST_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready) begin
               act_in  = req_act;
               l1a_in  = req_l1a;
               l2_in   = req_l2;
               code_in = req_code;
               unique case (req_act)
                  tcpm_pkg::ACT_LOOKUP: begin
                     if (req_mode_ok) begin
                        l1_ctl.rd_en = 1'b1;
                        state_in     = S_L1;
                     end else begin
                        fin_en   = 1'b1;
                        fin_code = tcpm_pkg::RSP_TDATA_W'(default_ff);
                     end
                  end
                  tcpm_pkg::ACT_STORE: begin
                     if (req_mode_ok) begin
                        l1_ctl.rd_en = 1'b1;
                        state_in     = S_L1;
                     end else begin
                        fin_en = 1'b1;
                     end
                  end
                  tcpm_pkg::ACT_SET_DEFAULT: begin
                     fin_en = 1'b1;
                     if (req_code != default_ff) begin
                        default_in             = req_code;
                        old_in                 = default_ff;
                        pool_ctl.rewrite_start = 1'b1;
                     end
                  end
                  tcpm_pkg::ACT_FLUSH: begin
                     fin_en       = 1'b1;
                     l1_ctl.clear = 1'b1;
                     nf_in        = '0;
                  end
                  default: fin_en = 1'b1;
               endcase
            end
         end
         S_L1: begin
            pool_addr = {l1_rd_table, l2_ff};
            if (act_ff == tcpm_pkg::ACT_LOOKUP) begin
               if (l1_rd_valid) begin
                  pool_ctl.rd_en = 1'b1;
                  state_in       = S_POOL;
               end else begin
                  fin_en   = 1'b1;
                  fin_code = tcpm_pkg::RSP_TDATA_W'(default_ff);
               end
            end else if (l1_rd_valid) begin
               // mapped slot: plain write
               pool_ctl.wr_en = 1'b1;
               fin_en         = 1'b1;
            end else if (nf_ff >= (TBL_W+1)'(POOL_TABLES)) begin
               fin_en     = 1'b1;
               fin_status = tcpm_pkg::ST_NO_TABLE;
            end else begin
               // take the next table and fill it with the default
               l1_ctl.wr_en        = 1'b1;
               pool_ctl.fill_start = 1'b1;
               cur_tbl_in          = nf_ff[TBL_W-1:0];
               nf_in               = nf_ff + 1'b1;
               state_in            = S_FILL;
            end
         end
         S_POOL: begin
            fin_en   = 1'b1;
            fin_code = tcpm_pkg::RSP_TDATA_W'(pool_rd_data);
         end
         S_FILL: begin
            if (!pool_busy) begin
               pool_ctl.wr_en = 1'b1;
               fin_en         = 1'b1;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_code_in   = hold_code_ff;
               rsp_status_in = hold_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // hand the response to the output register or park it
      if (fin_en) begin
         if (out_free) begin
            rsp_tvalid_in = 1'b1;
            rsp_code_in   = fin_code;
            rsp_status_in = fin_status;
            state_in      = S_IDLE;
         end else begin
            hold_code_in   = fin_code;
            hold_status_in = fin_status;
            state_in       = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nf_ff         <= '0;
         default_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         nf_ff          <= nf_in;
         default_ff     <= default_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         act_ff         <= act_in;
         l1a_ff         <= l1a_in;
         l2_ff          <= l2_in;
         code_ff        <= code_in;
         old_ff         <= old_in;
         cur_tbl_ff     <= cur_tbl_in;
         rsp_code_ff    <= rsp_code_in;
         rsp_status_ff  <= rsp_status_in;
         hold_code_ff   <= hold_code_in;
         hold_status_ff <= hold_status_in;
      end
   end

   // first-level map
   tcpm_l1_map #(
      .ADDR_W (L1A_W),
      .TBL_W  (TBL_W)
   ) u_l1_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      (l1_ctl),
      .rd_addr  (req_l1a),
      .wr_addr  (l1a_ff),
      .wr_table (nf_ff[TBL_W-1:0]),
      .rd_valid (l1_rd_valid),
      .rd_table (l1_rd_table),
      .busy     (l1_busy)
   );

   // second-level table pool
   tcpm_pool #(
      .TBL_W   (TBL_W),
      .L2_BITS (L2_BITS),
      .CODE_W  (CODE_BITS)
   ) u_pool (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pool_ctl),
      .addr        (pool_addr),
      .wr_data     (code_ff),
      .fill_table  (cur_tbl_in),
      .sweep_limit (nf_ff),
      .sweep_value (default_ff),
      .old_value   (old_ff),
      .rd_data     (pool_rd_data),
      .busy        (pool_busy)
   );

   assign req_tready = ready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_status_ff;

   // checks on sequencer and memory interlocks
   `TCPM_ASSERT(a_nf_bound, nf_ff <= (TBL_W+1)'(POOL_TABLES), "tables taken beyond pool size")
   `TCPM_ASSERT(a_pool_access_idle, (pool_ctl.rd_en || pool_ctl.wr_en) |-> !pool_busy, "pool access during sweep")
   `TCPM_ASSERT(a_l1_write_idle, l1_ctl.wr_en |-> !l1_busy, "map write during clearing sweep")
   `TCPM_ASSERT_NEXT(a_fill_runs, pool_ctl.fill_start, pool_busy && (state_ff == S_FILL), "fill did not start")
   `TCPM_ASSERT(a_hold_full, (state_ff == S_HOLD) |-> rsp_tvalid_ff, "response parked while output empty")

endmodule

`default_nettype wire
